// ----- src/rgb_background_calibrator_top_defines.svh -----
// ----------------------------------------------------------------------------
// RGB background calibrator assertion macros
// Concurrent assertion wrappers, clocked on clk; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef RGB_BACKGROUND_CALIBRATOR_TOP_DEFINES_SVH
`define RGB_BACKGROUND_CALIBRATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RBC_ASSERT(lbl, prop, msg)
`define RBC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- src/rbc_pkg.sv -----
// ----------------------------------------------------------------------------
// RGB background calibrator package
// Word types, register and model codes, and pipeline sizes shared by the block.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int NumLanes  = 3;
  localparam int SampleW   = 16;
  localparam int OutW      = 24;
  localparam int FracW     = 8;
  localparam int CfgW      = 48;
  localparam int QuotW     = 25;
  localparam int NumW      = 50;
  localparam int DenW      = 35;
  localparam int DivNumW   = 58;
  localparam int DivDenW   = 35;
  localparam int FrontStages = 3;
  localparam int Latency   = FrontStages + QuotW + 1;

  typedef enum logic [1:0] {
    REG_MODEL   = 2'd0,
    REG_MEDIANS = 2'd1,
    REG_MAXIMA  = 2'd2,
    REG_REFS    = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODEL_NONE     = 2'd0,
    MODEL_OFFSET   = 2'd1,
    MODEL_LINEAR   = 2'd2,
    MODEL_RATIONAL = 2'd3
  } model_t;

  typedef struct packed {
    logic [SampleW-1:0] red_in;
    logic [SampleW-1:0] green_in;
    logic [SampleW-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [OutW-1:0] red_out;
    logic [OutW-1:0] green_out;
    logic [OutW-1:0] blue_out;
  } result_t;

  typedef struct packed {
    model_t             model;
    logic [SampleW-1:0] median;
    logic [SampleW-1:0] maximum;
    logic [SampleW-1:0] reference;
  } chan_cfg_t;

  // Front end to divider: value is the final output when direct, else the cap.
  typedef struct packed {
    logic               valid;
    logic               direct;
    logic [OutW-1:0]    value;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_word_t;

endpackage

// ----- src/rbc_front.sv -----
// ----------------------------------------------------------------------------
// RGB background calibrator lane front end
// Forms the model's numerator, denominator and cap for one channel in three
// stages, and resolves every case that needs no division.
// ----------------------------------------------------------------------------
module rbc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [rbc_pkg::SampleW-1:0] sample,
  input  rbc_pkg::chan_cfg_t          cfg,
  output rbc_pkg::div_word_t          word
);

  localparam int NumW_L = rbc_pkg::NumW;
  localparam int DenW_L = rbc_pkg::DenW;

  logic signed [16:0] xs, ms, bs, rs;
  logic signed [16:0] m_minus_r, r_minus_b, b_minus_m, b_minus_r, x_minus_m, m_minus_b;

  // Stage 1: products.
  logic               s1_valid;
  logic [15:0]        s1_x;
  logic [31:0]        s1_xr;
  logic signed [33:0] s1_pa, s1_pb, s1_pl1, s1_pl2;

  assign xs = $signed({1'b0, sample});
  assign ms = $signed({1'b0, cfg.median});
  assign bs = $signed({1'b0, cfg.maximum});
  assign rs = $signed({1'b0, cfg.reference});
  assign m_minus_r = ms - rs;
  assign r_minus_b = rs - bs;
  assign b_minus_m = bs - ms;
  assign b_minus_r = bs - rs;
  assign x_minus_m = xs - ms;
  assign m_minus_b = ms - bs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_x   <= sample;
    s1_xr  <= 32'(sample) * 32'(cfg.reference);
    s1_pa  <= 34'(m_minus_r) * 34'(xs);
    s1_pb  <= 34'(ms) * 34'(r_minus_b);
    s1_pl1 <= 34'(rs) * 34'(b_minus_m);
    s1_pl2 <= 34'(b_minus_r) * 34'(x_minus_m);
  end

  // Stage 2: model selection.
  logic                 s2_valid, s2_direct, s2_direct_next;
  logic [23:0]          s2_value, s2_value_next;
  logic signed [NumW_L-1:0] s2_num, s2_num_next;
  logic signed [DenW_L-1:0] s2_den, s2_den_next;

  logic [15:0]        lim_off, lim_rat, x_rat;
  logic signed [17:0] v_off, v_clip;
  logic [17:0]        v_abs;
  logic signed [NumW_L-1:0] xr_s;

  always_comb begin
    lim_off = (cfg.median > cfg.maximum) ? cfg.median : cfg.maximum;
    lim_rat = (cfg.reference > cfg.maximum) ? cfg.reference : cfg.maximum;
    x_rat   = (s1_x < lim_rat) ? s1_x : lim_rat;
    v_off   = $signed({2'b0, s1_x}) + $signed({2'b0, cfg.reference})
              - $signed({2'b0, cfg.median});
    v_clip  = (v_off > $signed({2'b0, lim_off})) ? $signed({2'b0, lim_off}) : v_off;
    v_abs   = v_clip[17] ? 18'(-v_clip) : 18'(v_clip);
    xr_s    = $signed({18'b0, s1_xr});
    s2_direct_next = 1'b1;
    s2_value_next  = {s1_x, 8'h00};
    s2_num_next    = '0;
    s2_den_next    = '0;
    unique case (cfg.model)
      rbc_pkg::MODEL_NONE: begin
        s2_value_next = {s1_x, 8'h00};
      end
      rbc_pkg::MODEL_OFFSET: begin
        s2_value_next = {v_abs[15:0], 8'h00};
      end
      rbc_pkg::MODEL_LINEAR: begin
        if (s1_x < cfg.median) begin
          s2_direct_next = 1'b0;
          s2_value_next  = 24'hFFFFFF;
          s2_num_next    = xr_s;
          s2_den_next    = 35'($signed({1'b0, cfg.median}));
        end else if (cfg.median < cfg.maximum) begin
          s2_direct_next = 1'b0;
          s2_value_next  = 24'hFFFFFF;
          s2_num_next    = 50'(s1_pl1) + 50'(s1_pl2);
          s2_den_next    = 35'(bs - ms);
        end else begin
          s2_value_next = {cfg.reference, 8'h00};
        end
      end
      rbc_pkg::MODEL_RATIONAL: begin
        if (cfg.maximum != '0 && cfg.reference != '0 && cfg.median != cfg.maximum) begin
          s2_direct_next = 1'b0;
          s2_value_next  = {lim_rat, 8'h00};
          s2_num_next    = xr_s * 50'(m_minus_b);
          s2_den_next    = 35'(s1_pa) + 35'(s1_pb);
        end else if (cfg.reference != '0 && cfg.median != '0) begin
          s2_direct_next = 1'b0;
          s2_value_next  = {lim_rat, 8'h00};
          s2_num_next    = xr_s;
          s2_den_next    = 35'($signed({1'b0, cfg.median}));
        end else begin
          s2_value_next = {x_rat, 8'h00};
        end
      end
      default: begin
        s2_value_next = {s1_x, 8'h00};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_direct <= s2_direct_next;
    s2_value  <= s2_value_next;
    s2_num    <= s2_num_next;
    s2_den    <= s2_den_next;
  end

  // Stage 3: signs, zero cases and the quotient range check.
  logic [NumW_L-1:0]             un_full;
  logic [DenW_L-1:0]             ud_full;
  logic [47:0]                   un;
  logic [33:0]                   ud;
  logic [rbc_pkg::DivNumW-1:0]   num_div;
  logic [rbc_pkg::DivDenW-1:0]   den_div;
  logic                          ovf;
  rbc_pkg::div_word_t            word_next;

  always_comb begin
    un_full = s2_num[NumW_L-1] ? NumW_L'(-s2_num) : NumW_L'(s2_num);
    ud_full = s2_den[DenW_L-1] ? DenW_L'(-s2_den) : DenW_L'(s2_den);
    un      = un_full[47:0];
    ud      = ud_full[33:0];
    num_div = 58'({un, 9'b0}) + 58'(ud);
    den_div = {ud, 1'b0};
    // A quotient of 2^25 or more is above any cap.
    ovf     = 60'(num_div) >= {den_div, 25'b0};
    word_next.valid  = s2_valid;
    word_next.direct = 1'b1;
    word_next.value  = s2_value;
    word_next.num    = num_div;
    word_next.den    = den_div;
    if (!s2_direct) begin
      if (s2_num == '0) begin
        word_next.value = '0;
      end else if (s2_den == '0) begin
        word_next.value = s2_value;
      end else if (s2_num[NumW_L-1] != s2_den[DenW_L-1]) begin
        word_next.value = '0;
      end else if (!ovf) begin
        word_next.direct = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else begin
      word.valid <= word_next.valid;
    end
    word.direct <= word_next.direct;
    word.value  <= word_next.value;
    word.num    <= word_next.num;
    word.den    <= word_next.den;
  end

endmodule

// ----- src/rbc_div.sv -----
// ----------------------------------------------------------------------------
// RGB background calibrator lane divider
// Restoring division, one quotient bit per pipeline stage, then the clamp to
// the model's cap.
// ----------------------------------------------------------------------------
module rbc_div (
  input  logic                     clk,
  input  logic                     rst,
  input  rbc_pkg::div_word_t       word,
  output logic                     valid,
  output logic [rbc_pkg::OutW-1:0] value
);

  localparam int Q  = rbc_pkg::QuotW;
  localparam int DW = rbc_pkg::DivDenW;

  typedef struct packed {
    logic                     valid;
    logic                     direct;
    logic [rbc_pkg::OutW-1:0] value;
    logic [DW-1:0]            rem;
    logic [Q-1:0]             num_lo;
    logic [DW-1:0]            den;
    logic [Q-1:0]             quot;
  } stage_t;

  stage_t stg [0:Q];

  always_comb begin
    stg[0].valid  = word.valid;
    stg[0].direct = word.direct;
    stg[0].value  = word.value;
    stg[0].rem    = DW'(word.num[rbc_pkg::DivNumW-1:Q]);
    stg[0].num_lo = word.num[Q-1:0];
    stg[0].den    = word.den;
    stg[0].quot   = '0;
  end

  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [DW:0] trial;
    logic        take;

    assign trial = {stg[k].rem, stg[k].num_lo[Q-1]};
    assign take  = trial >= {1'b0, stg[k].den};

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k+1].valid <= 1'b0;
      end else begin
        stg[k+1].valid <= stg[k].valid;
      end
      stg[k+1].direct <= stg[k].direct;
      stg[k+1].value  <= stg[k].value;
      stg[k+1].rem    <= take ? DW'(trial - {1'b0, stg[k].den}) : DW'(trial);
      stg[k+1].num_lo <= {stg[k].num_lo[Q-2:0], 1'b0};
      stg[k+1].den    <= stg[k].den;
      stg[k+1].quot   <= {stg[k].quot[Q-2:0], take};
    end
  end

  assign valid = stg[Q].valid;

  always_comb begin
    if (stg[Q].direct || stg[Q].quot > {1'b0, stg[Q].value}) begin
      value = stg[Q].value;
    end else begin
      value = stg[Q].quot[rbc_pkg::OutW-1:0];
    end
  end

endmodule

// ----- src/rbc_merge.sv -----
// ----------------------------------------------------------------------------
// RGB background calibrator merge stage
// Gathers the three channel lanes into one result word and its strobe.
// ----------------------------------------------------------------------------
module rbc_merge (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [rbc_pkg::NumLanes-1:0] lane_valid,
  input  logic [rbc_pkg::OutW-1:0] lane_value [rbc_pkg::NumLanes],
  output logic                     done,
  output rbc_pkg::result_t         result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= &lane_valid;
    end
    result.red_out   <= lane_value[0];
    result.green_out <= lane_value[1];
    result.blue_out  <= lane_value[2];
  end

endmodule

// ----- src/rgb_background_calibrator_top.sv -----
// ----------------------------------------------------------------------------
// RGB background calibrator top level
// One pixel enters per clock whenever busy is low; the calibrated word for it
// appears with done exactly 29 cycles after the start cycle, in input order,
// and is held for that one cycle only, so the receiver must take it then.
// The latency is set by the three front stages, the 25-stage restoring
// divider of each channel lane and the output register. busy is high only
// during reset. Configuration writes take effect at once and must be made
// with no pixel in flight.
// ----------------------------------------------------------------------------
`include "rgb_background_calibrator_top_defines.svh"

module rgb_background_calibrator_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  rbc_pkg::pixel_t          pixel,
  output logic                     done,
  output rbc_pkg::result_t         result,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_index,
  input  logic [rbc_pkg::CfgW-1:0] cfg_data
);

  rbc_pkg::model_t           model_select;
  logic [rbc_pkg::CfgW-1:0]  frame_medians, frame_maxima, reference_levels;
  logic                      accept;
  logic [rbc_pkg::SampleW-1:0] sample [rbc_pkg::NumLanes];
  logic [rbc_pkg::NumLanes-1:0] lane_valid;
  logic [rbc_pkg::OutW-1:0]  lane_value [rbc_pkg::NumLanes];

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_select     <= rbc_pkg::MODEL_NONE;
      frame_medians    <= '0;
      frame_maxima     <= '0;
      reference_levels <= '0;
    end else if (cfg_wr_en) begin
      unique case (rbc_pkg::cfg_reg_t'(cfg_index))
        rbc_pkg::REG_MODEL:   model_select     <= rbc_pkg::model_t'(cfg_data[1:0]);
        rbc_pkg::REG_MEDIANS: frame_medians    <= cfg_data;
        rbc_pkg::REG_MAXIMA:  frame_maxima     <= cfg_data;
        rbc_pkg::REG_REFS:    reference_levels <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample[0] = pixel.red_in;
  assign sample[1] = pixel.green_in;
  assign sample[2] = pixel.blue_in;

  for (genvar i = 0; i < rbc_pkg::NumLanes; i++) begin : g_lane
    rbc_pkg::chan_cfg_t ccfg;
    rbc_pkg::div_word_t word;

    assign ccfg.model     = model_select;
    assign ccfg.median    = frame_medians[rbc_pkg::SampleW*i +: rbc_pkg::SampleW];
    assign ccfg.maximum   = frame_maxima[rbc_pkg::SampleW*i +: rbc_pkg::SampleW];
    assign ccfg.reference = reference_levels[rbc_pkg::SampleW*i +: rbc_pkg::SampleW];

    rbc_front u_front (
      .clk    (clk),
      .rst    (rst),
      .accept (accept),
      .sample (sample[i]),
      .cfg    (ccfg),
      .word   (word)
    );

    rbc_div u_div (
      .clk   (clk),
      .rst   (rst),
      .word  (word),
      .valid (lane_valid[i]),
      .value (lane_value[i])
    );
  end

  rbc_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (lane_valid),
    .lane_value (lane_value),
    .done       (done),
    .result     (result)
  );

  // Every accepted pixel gives exactly one word, a fixed time later.
  `RBC_ASSERT_ALWAYS(a_quiet_after_reset, rst |=> !done, "done right after reset")
  `RBC_ASSERT(a_latency, accept |-> ##(rbc_pkg::Latency) done, "result word missing")
  `RBC_ASSERT(a_no_spurious, done |-> $past(accept, rbc_pkg::Latency), "unrequested word")
  `RBC_ASSERT(a_lanes_agree,
    $countones(lane_valid) == 0 || $countones(lane_valid) == rbc_pkg::NumLanes,
    "channel lanes out of step")

endmodule
